>>> src/cardinal_bspline_evaluator_core_macros.svh
// Assertion macros for the cardinal B-spline evaluator.
`ifndef CARDINAL_BSPLINE_EVALUATOR_CORE_MACROS_SVH
`define CARDINAL_BSPLINE_EVALUATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/cbs_pkg.sv
package cbs_pkg;
  localparam int MAX_ORDER = 16;
  localparam int FRAC_BITS = 16;
  localparam int X_W = 8 + FRAC_BITS;
  localparam int OUT_W = FRAC_BITS + 1;
  localparam int IDX_W = $clog2(MAX_ORDER);
  localparam int K_W = 5;
  localparam int RC_W = FRAC_BITS + 1;
  localparam int ST_W = FRAC_BITS + 2;
  localparam logic [ST_W-1:0] ONE_FX = ST_W'(1) << FRAC_BITS;
  localparam int ONE_I = 1 << FRAC_BITS;

  // Rounded reciprocals of the small integers; entry zero stands in for one.
  localparam logic [RC_W-1:0] RECIP_ROM [MAX_ORDER] = '{
    RC_W'(ONE_I),
    RC_W'(ONE_I),
    RC_W'((ONE_I + 1) / 2),
    RC_W'((ONE_I + 1) / 3),
    RC_W'((ONE_I + 2) / 4),
    RC_W'((ONE_I + 2) / 5),
    RC_W'((ONE_I + 3) / 6),
    RC_W'((ONE_I + 3) / 7),
    RC_W'((ONE_I + 4) / 8),
    RC_W'((ONE_I + 4) / 9),
    RC_W'((ONE_I + 5) / 10),
    RC_W'((ONE_I + 5) / 11),
    RC_W'((ONE_I + 6) / 12),
    RC_W'((ONE_I + 6) / 13),
    RC_W'((ONE_I + 7) / 14),
    RC_W'((ONE_I + 7) / 15)
  };

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_RD, S_AL, S_MUL, S_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] {U_COL, U_TOP, U_BOT} upd_t;

  typedef struct packed {
    logic start;
    logic setup;
    logic rd;
    logic al;
    logic mul;
    logic wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic last;
    logic out_full;
  } sts_t;

  function automatic logic [RC_W-1:0] recip(input logic [K_W-1:0] n);
    begin
      recip = RECIP_ROM[n[IDX_W-1:0]];
    end
  endfunction
endpackage

>>> src/cardinal_bspline_evaluator_core.sv
// Channel | Direction | Payload
// in_     | input     | x_value, signed Q8.16
// out_    | output    | spline_value Q1.16, in_support
// cfg_    | input     | spline_order, five bits
// A new request is accepted only once the engine is back in its idle state. Each of its
// U = (r+1)*(k-1-r) + r store updates, with r = ceil(x)-1 after folding, passes
// through the read, align, multiply and write states. Points outside the support,
// and any point at order one, skip them. Reset sets the order to four.
// A waiting result holds the engine in its last state until it is taken.
`include "cardinal_bspline_evaluator_core_macros.svh"
module cardinal_bspline_evaluator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cbs_pkg::X_W-1:0]       in_x_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbs_pkg::OUT_W-1:0]     out_spline_value,
  output logic                          out_in_support,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbs_pkg::K_W-1:0]       cfg_spline_order
);
  logic [cbs_pkg::K_W-1:0] order_r;
  logic out_valid_r, busy, in_fire;
  cbs_pkg::cmd_t cmd;
  cbs_pkg::sts_t sts;

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= cbs_pkg::K_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) order_r <= cfg_spline_order;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  cbs_ctrl u_ctrl (.clk, .rst_n, .in_fire, .sts, .cmd, .busy);
  cbs_dp u_dp (.clk, .order(order_r), .x_in(in_x_value), .cmd, .sts,
    .out_full(out_valid_r && !out_ready), .res_value(out_spline_value),
    .res_support(out_in_support));

  `CBS_ASSERT_IMPL(a_no_start_busy, clk, rst_n, busy, !in_ready)
  `CBS_ASSERT_IMPL(a_val_range, clk, rst_n, out_valid, out_spline_value <= 17'h10000)
  `CBS_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid)
endmodule

>>> src/cbs_ctrl.sv
module cbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  cbs_pkg::sts_t sts,
  output cbs_pkg::cmd_t cmd,
  output logic          busy
);
  cbs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cbs_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbs_pkg::S_IDLE:  if (in_fire) state_nxt = cbs_pkg::S_SETUP;
      cbs_pkg::S_SETUP: state_nxt = sts.outside ? cbs_pkg::S_DONE : cbs_pkg::S_RD;
      cbs_pkg::S_RD:    state_nxt = cbs_pkg::S_AL;
      cbs_pkg::S_AL:    state_nxt = cbs_pkg::S_MUL;
      cbs_pkg::S_MUL:   state_nxt = cbs_pkg::S_WR;
      cbs_pkg::S_WR:    state_nxt = sts.last ? cbs_pkg::S_DONE : cbs_pkg::S_RD;
      cbs_pkg::S_DONE:  if (!sts.out_full) state_nxt = cbs_pkg::S_IDLE;
      default:          state_nxt = cbs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      cbs_pkg::S_IDLE:  begin busy = 1'b0; cmd.start = in_fire; end
      cbs_pkg::S_SETUP: cmd.setup = 1'b1;
      cbs_pkg::S_RD:    cmd.rd = 1'b1;
      cbs_pkg::S_AL:    cmd.al = 1'b1;
      cbs_pkg::S_MUL:   cmd.mul = 1'b1;
      cbs_pkg::S_WR:    cmd.wr = 1'b1;
      cbs_pkg::S_DONE:  cmd.finish = !sts.out_full;
      default:          busy = 1'b1;
    endcase
  end
endmodule

>>> src/cbs_dp.sv
module cbs_dp (
  input  logic                        clk,
  input  logic [cbs_pkg::K_W-1:0]     order,
  input  logic [cbs_pkg::X_W-1:0]     x_in,
  input  cbs_pkg::cmd_t               cmd,
  output cbs_pkg::sts_t               sts,
  input  logic                        out_full,
  output logic [cbs_pkg::OUT_W-1:0]   res_value,
  output logic                        res_support
);
  localparam int XW = cbs_pkg::X_W + 2;
  localparam int FB = cbs_pkg::FRAC_BITS;
  localparam int SW = cbs_pkg::ST_W;
  localparam int KW = cbs_pkg::K_W;
  localparam int IW = cbs_pkg::IDX_W;

  logic [SW-1:0] store_r [cbs_pkg::MAX_ORDER];
  logic signed [XW-1:0] x_r, xin_r;
  logic [KW-1:0] k_r, r_r, j_r, ug_r, og_r, idx_r, g1_r, g2_r;
  cbs_pkg::upd_t kind_r;
  logic outside_r;
  logic [SW-1:0] left_r, right_r, a_r;
  logic [2*SW-1:0] p0_r, p1_r;
  logic signed [XW-1:0] kfx, xf, d;
  logic [KW-1:0] k_eff, n, pos, r_c, col_lo;
  logic inside_c;
  logic [XW-1:0] dc;
  logic [XW+cbs_pkg::RC_W-1:0] prod;
  logic [XW+cbs_pkg::RC_W-1:0] ash;
  logic [2*SW:0] acc, vsh;
  logic [SW-1:0] v;
  logic [KW-1:0] ug_n, og_n, idx_n, j_n;
  cbs_pkg::upd_t kind_n;
  logic last_n, step_end;

  assign k_eff = (order > KW'(cbs_pkg::MAX_ORDER)) ? KW'(cbs_pkg::MAX_ORDER) : order;
  assign kfx = XW'(k_r) <<< FB;
  assign xf = ((kfx - xin_r) < xin_r) ? (kfx - xin_r) : xin_r;
  assign inside_c = (k_r != '0) && (xin_r > 0) && (xin_r < kfx);
  assign r_c = KW'((xf - 1) >>> FB);

  assign pos = (kind_r == cbs_pkg::U_BOT) ? ug_r : idx_r;
  assign n = k_r - j_r;
  assign d = x_r - ((XW'(pos) + XW'(r_r) + XW'(1) - XW'(k_r)) <<< FB);
  always_comb begin
    if (d < 0) dc = '0;
    else if (d > (XW'(n) <<< FB)) dc = XW'(n) << FB;
    else dc = d;
  end
  assign prod = dc * cbs_pkg::recip(n) + (XW+cbs_pkg::RC_W)'(1 << (FB-1));
  assign ash = prod >> FB;

  assign acc = (2*SW+1)'(p0_r) + (2*SW+1)'(p1_r) + (2*SW+1)'(1 << (FB-1));
  assign vsh = acc >> FB;
  assign v = (vsh > (2*SW+1)'(cbs_pkg::ONE_FX)) ? cbs_pkg::ONE_FX : SW'(vsh);

  always_comb begin
    ug_n = ug_r; og_n = og_r; idx_n = idx_r; j_n = j_r; kind_n = kind_r;
    last_n = 1'b0;
    step_end = 1'b0;
    col_lo = (j_r > g2_r) ? ug_r : ug_r + KW'(1);
    case (kind_r)
      cbs_pkg::U_TOP: begin
        if (og_r - KW'(1) > ug_r) begin
          kind_n = cbs_pkg::U_COL;
          idx_n = og_r - KW'(1);
        end else begin
          kind_n = cbs_pkg::U_BOT;
        end
      end
      cbs_pkg::U_COL: begin
        if (idx_r > col_lo) idx_n = idx_r - KW'(1);
        else if (j_r <= g2_r) kind_n = cbs_pkg::U_BOT;
        else step_end = 1'b1;
      end
      cbs_pkg::U_BOT: step_end = 1'b1;
      default: step_end = 1'b1;
    endcase
    if (step_end) begin
      j_n = j_r + KW'(1);
      if (j_n >= k_r) last_n = 1'b1;
      if (j_n <= g1_r) begin
        og_n = og_r + KW'(1); kind_n = cbs_pkg::U_TOP; idx_n = og_r + KW'(1);
      end else if (j_n <= g2_r) begin
        kind_n = cbs_pkg::U_COL; idx_n = og_r;
        if (og_r < ug_r + KW'(1)) kind_n = cbs_pkg::U_BOT;
      end else begin
        ug_n = ug_r + KW'(1); kind_n = cbs_pkg::U_COL; idx_n = og_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      xin_r <= XW'(signed'(x_in));
      k_r <= k_eff;
      for (int i = 0; i < cbs_pkg::MAX_ORDER; i++) store_r[i] <= '0;
    end
    if (cmd.setup) begin
      outside_r <= !inside_c;
      x_r <= xf;
      r_r <= r_c;
      g1_r <= r_c;
      g2_r <= k_r - KW'(1) - r_c;
      ug_r <= k_r - KW'(1) - r_c;
      j_r <= KW'(1);
      if (inside_c)
        store_r[IW'(k_r - r_c - KW'(1))] <= cbs_pkg::ONE_FX;
      if (r_c >= KW'(1)) begin
        kind_r <= cbs_pkg::U_TOP;
        idx_r <= k_r - r_c;
        og_r <= k_r - r_c;
      end else begin
        kind_r <= cbs_pkg::U_BOT;
        idx_r <= k_r - KW'(1);
        og_r <= k_r - KW'(1);
      end
    end
    if (cmd.rd) begin
      left_r <= (kind_r == cbs_pkg::U_BOT) ? '0 : store_r[IW'(pos - KW'(1))];
      right_r <= (kind_r == cbs_pkg::U_TOP) ? '0 : store_r[IW'(pos)];
    end
    if (cmd.al) a_r <= (ash > (XW+cbs_pkg::RC_W)'(cbs_pkg::ONE_FX)) ? cbs_pkg::ONE_FX
                       : SW'(ash);
    if (cmd.mul) begin
      p0_r <= (cbs_pkg::ONE_FX - a_r) * left_r;
      p1_r <= a_r * right_r;
    end
    if (cmd.wr) begin
      store_r[IW'(pos)] <= v;
      ug_r <= ug_n; og_r <= og_n; idx_r <= idx_n; j_r <= j_n; kind_r <= kind_n;
    end
    if (cmd.finish) begin
      res_value <= outside_r ? '0 : store_r[IW'(k_r - KW'(1))][cbs_pkg::OUT_W-1:0];
      res_support <= !outside_r;
    end
  end

  assign sts.outside = !inside_c || (k_r == KW'(1));
  assign sts.last = last_n;
  assign sts.out_full = out_full;
endmodule
